>>> sv/dcil_pkg.sv
// Shared types and constants of the DCT coefficient index locator.
`timescale 1ns / 1ps

package dcil_pkg;

  localparam int MAX_COMPONENTS  = 3;
  localparam int COEFS_PER_BLOCK = 64;
  localparam int POS_W           = $clog2(COEFS_PER_BLOCK);
  localparam int IDX_W           = 32;
  localparam int BLK_W           = IDX_W - POS_W;
  localparam int WID_W           = 14;
  localparam int ROW_W           = 13;
  localparam int DIV_STEPS       = BLK_W / 2;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [WID_W-1:0] MAX_WIDTH = 14'd8192;
  localparam logic [ROW_W-1:0] ROW_MAX   = 13'h1fff;

  // Register indexes, byte address 4*index.
  localparam logic [2:0] REG_COMP_COUNT = 3'd0;
  localparam logic [2:0] REG_TOTAL_0    = 3'd1;
  localparam logic [2:0] REG_TOTAL_1    = 3'd2;
  localparam logic [2:0] REG_TOTAL_2    = 3'd3;
  localparam logic [2:0] REG_WIDTH_0    = 3'd4;
  localparam logic [2:0] REG_WIDTH_1    = 3'd5;
  localparam logic [2:0] REG_WIDTH_2    = 3'd6;

  typedef struct packed {
    logic [1:0]                          comp_n;
    logic [MAX_COMPONENTS-1:0][IDX_W-1:0] total;
    logic [MAX_COMPONENTS-1:0][WID_W-1:0] width;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic search;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic oor;
    logic div_last;
  } sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> sv/dcil_regs.sv
// Configuration register file with APB-style access and range clamping.
`timescale 1ns / 1ps

module dcil_regs import dcil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output cfg_t        cfg
);

  logic [1:0]                           comp_count_r, comp_count_nxt;
  logic [MAX_COMPONENTS-1:0][IDX_W-1:0] total_r, total_nxt;
  logic [MAX_COMPONENTS-1:0][WID_W-1:0] width_r, width_nxt;
  logic                                 wr_en;
  logic [2:0]                           reg_idx;

  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx = cfg_paddr[4:2];

  always_comb begin
    comp_count_nxt = comp_count_r;
    total_nxt      = total_r;
    width_nxt      = width_r;
    if (wr_en) begin
      case (reg_idx)
        REG_COMP_COUNT: comp_count_nxt = cfg_pwdata[1:0];
        REG_TOTAL_0:    total_nxt[0]   = cfg_pwdata;
        REG_TOTAL_1:    total_nxt[1]   = cfg_pwdata;
        REG_TOTAL_2:    total_nxt[2]   = cfg_pwdata;
        REG_WIDTH_0:    width_nxt[0]   = cfg_pwdata[WID_W-1:0];
        REG_WIDTH_1:    width_nxt[1]   = cfg_pwdata[WID_W-1:0];
        REG_WIDTH_2:    width_nxt[2]   = cfg_pwdata[WID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_count_r <= 2'd3;
      total_r      <= '0;
      width_r      <= {MAX_COMPONENTS{14'd1}};
    end else begin
      comp_count_r <= comp_count_nxt;
      total_r      <= total_nxt;
      width_r      <= width_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COMP_COUNT: cfg_prdata = {30'd0, comp_count_r};
      REG_TOTAL_0:    cfg_prdata = total_r[0];
      REG_TOTAL_1:    cfg_prdata = total_r[1];
      REG_TOTAL_2:    cfg_prdata = total_r[2];
      REG_WIDTH_0:    cfg_prdata = {18'd0, width_r[0]};
      REG_WIDTH_1:    cfg_prdata = {18'd0, width_r[1]};
      REG_WIDTH_2:    cfg_prdata = {18'd0, width_r[2]};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // A component count of zero acts as one; widths are held to 1..8192.
  always_comb begin
    cfg.comp_n = (comp_count_r == 2'd0) ? 2'd1 : comp_count_r;
    cfg.total  = total_r;
    for (int i = 0; i < MAX_COMPONENTS; i++) begin
      if (width_r[i] == '0) begin
        cfg.width[i] = 14'd1;
      end else if (width_r[i] > MAX_WIDTH) begin
        cfg.width[i] = MAX_WIDTH;
      end else begin
        cfg.width[i] = width_r[i];
      end
    end
  end

endmodule

>>> sv/dcil_ctrl.sv
// Controller state machine that sequences search, division and result hand-off.
`timescale 1ns / 1ps

module dcil_ctrl import dcil_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.search_done) state_nxt = sts.oor ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SEARCH: cmd.search   = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_DONE:   cmd.finish   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/dcil_dpath.sv
// Datapath: component search, block index divider, usable counter, output register.
`timescale 1ns / 1ps

module dcil_dpath import dcil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser
);

  logic [IDX_W-1:0]     local_r, local_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic signed [15:0]   coef_r;
  logic                 restart_r;
  logic                 oor_r, oor_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [WID_W-1:0]     w_r, w_nxt;
  logic [BLK_W-1:0]     dvd_r, dvd_nxt;
  logic [BLK_W-1:0]     quot_r, quot_nxt;
  logic [ROW_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [31:0]          count_r, count_nxt;

  logic [IDX_W-1:0] total_sel;
  logic [WID_W-1:0] width_sel;
  logic             found;

  logic [WID_W-1:0] r1, r2;
  logic [ROW_W-1:0] r1s, r2s;
  logic             q1, q2;

  logic [31:0]      count_base;
  logic             use_item;
  logic [ROW_W-1:0] row;

  logic [1:0]       o_comp_r;
  logic [ROW_W-1:0] o_row_r, o_col_r;
  logic [POS_W-1:0] o_pos_r;
  logic             o_dc_r, o_use_r, o_oor_r;
  logic [31:0]      o_rank_r;

  always_comb begin
    case (comp_r)
      2'd0:    begin total_sel = cfg.total[0]; width_sel = cfg.width[0]; end
      2'd1:    begin total_sel = cfg.total[1]; width_sel = cfg.width[1]; end
      2'd2:    begin total_sel = cfg.total[2]; width_sel = cfg.width[2]; end
      default: begin total_sel = '0;           width_sel = 14'd1;        end
    endcase
  end

  assign found           = local_r < total_sel;
  assign sts.oor         = comp_r >= cfg.comp_n;
  assign sts.search_done = sts.oor || found;
  assign sts.div_last    = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);

  // Two restoring steps per cycle; the remainder always stays below the width.
  always_comb begin
    r1  = {rem_r, dvd_r[BLK_W-1]};
    q1  = r1 >= w_r;
    r1s = q1 ? ROW_W'(r1 - w_r) : r1[ROW_W-1:0];
    r2  = {r1s, dvd_r[BLK_W-2]};
    q2  = r2 >= w_r;
    r2s = q2 ? ROW_W'(r2 - w_r) : r2[ROW_W-1:0];
  end

  always_comb begin
    local_nxt   = local_r;
    comp_nxt    = comp_r;
    oor_nxt     = oor_r;
    pos_nxt     = pos_r;
    w_nxt       = w_r;
    dvd_nxt     = dvd_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.load) begin
      local_nxt = in_tdata[IDX_W-1:0];
      comp_nxt  = 2'd0;
    end else if (cmd.search) begin
      if (sts.search_done) begin
        oor_nxt     = sts.oor;
        pos_nxt     = local_r[POS_W-1:0];
        dvd_nxt     = local_r[IDX_W-1:POS_W];
        w_nxt       = width_sel;
        quot_nxt    = '0;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
      end else begin
        local_nxt = local_r - total_sel;
        comp_nxt  = comp_r + 2'd1;
      end
    end else if (cmd.div_step) begin
      dvd_nxt     = {dvd_r[BLK_W-3:0], 2'b00};
      quot_nxt    = {quot_r[BLK_W-3:0], q1, q2};
      rem_nxt     = r2s;
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    local_r   <= local_nxt;
    comp_r    <= comp_nxt;
    oor_r     <= oor_nxt;
    pos_r     <= pos_nxt;
    w_r       <= w_nxt;
    dvd_r     <= dvd_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (cmd.load) begin
      coef_r    <= in_tdata[47:32];
      restart_r <= in_tuser;
    end
  end

  // Restart clears the count before this beat takes its rank.
  assign count_base = restart_r ? 32'd0 : count_r;
  assign use_item   = !oor_r && (pos_r != '0) && (coef_r != 16'sd0);
  assign row        = (quot_r[BLK_W-1:ROW_W] != '0) ? ROW_MAX : quot_r[ROW_W-1:0];
  assign count_nxt  = cmd.finish ? (count_base + {31'd0, use_item}) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 32'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_rank_r <= count_base;
      o_use_r  <= use_item;
      o_oor_r  <= oor_r;
      if (oor_r) begin
        o_comp_r <= '0;
        o_row_r  <= '0;
        o_col_r  <= '0;
        o_pos_r  <= '0;
        o_dc_r   <= 1'b0;
      end else begin
        o_comp_r <= comp_r;
        o_row_r  <= row;
        o_col_r  <= rem_r;
        o_pos_r  <= pos_r;
        o_dc_r   <= pos_r == '0;
      end
    end
  end

  assign out_tdata = {6'd0, o_rank_r, o_pos_r, o_col_r, o_row_r, o_comp_r};
  assign out_tuser = {o_oor_r, o_use_r, o_dc_r};

endmodule

>>> sv/dct_coefficient_index_locator_core.sv
// Top level of the DCT coefficient index locator.
`timescale 1ns / 1ps

// Maps a flat coefficient index over all components to component, block row,
// block column and position in the 64-coefficient block, flags DC and usable
// (AC, nonzero) coefficients and ranks usable ones in a running count that the
// restart flag clears. One item is in work at a time. An index that lands in a
// component is loaded, passes the component search (one subtraction per
// component, ending early when it hits) and the block index divider (two
// quotient bits per cycle against the component width) and then reaches the
// output register. An out-of-range index skips the divider after the search.
// The next input beat is taken while a finished result still waits on the
// output side; its own result then stalls until the waiting one has been taken.
module dct_coefficient_index_locator_core import dcil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // flat_index[31:0], coef_value[47:32]
  input  logic [47:0] in_tdata,
  // restart[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // component[1:0], block_row[14:2], block_col[27:15], coef_pos[33:28],
  // usable_rank[65:34], zero fill above
  output logic [71:0] out_tdata,
  // is_dc[0], usable[1], out_of_range[2]
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_pready = 1'b1;

  dcil_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg         (cfg)
  );

  dcil_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dcil_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // An accepted beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a beat");

  // An out-of-range result carries no location and is never usable.
  a_oor_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (!out_tuser[1] && !out_tuser[0] &&
                                      out_tdata[33:0] == 34'd0))
    else $error("out-of-range result with nonzero location fields");

  // A DC coefficient is never counted as usable.
  a_dc_not_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("DC coefficient flagged usable");

  // The controller issues at most one datapath command per cycle.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.search, cmd.div_step, cmd.finish}))
    else $error("controller issued overlapping commands");

endmodule

>>> tb/dct_coefficient_index_locator_core_test.sv
// Self-checking testbench of the DCT coefficient index locator core.
`timescale 1ns / 1ps

module dct_coefficient_index_locator_core_test import dcil_pkg::*;;

  localparam int          STALL_LIMIT  = 5000;
  localparam int          PHASE_ITEMS  = 250;
  localparam int          PHASES       = 8;
  localparam int          PRESSURE_AT  = 500;
  localparam int          PRESSURE_LEN = 400;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;

  typedef struct packed {
    logic [1:0]       comp;
    logic [ROW_W-1:0] row;
    logic [12:0]      col;
    logic [POS_W-1:0] pos;
    logic             is_dc;
    logic             usable;
    logic [31:0]      rank;
    logic             oor;
  } loc_result_t;

  // Tracks the register settings and the usable count, and holds the located
  // results that are still owed by the block.
  class locator_scoreboard;
    logic [1:0]       comp_n;
    logic [31:0]      total[MAX_COMPONENTS];
    logic [WID_W-1:0] width[MAX_COMPONENTS];
    logic [31:0]      usable_count;
    loc_result_t      located_q[$];
    int               fails;

    function new();
      comp_n = 2'd3;
      for (int k = 0; k < MAX_COMPONENTS; k++) begin
        total[k] = '0;
        width[k] = 14'd1;
      end
      usable_count = '0;
      fails = 0;
    endfunction

    function int active();
      if (comp_n == 0) return 1;
      if (comp_n > MAX_COMPONENTS) return MAX_COMPONENTS;
      return int'(comp_n);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_COMP_COUNT: comp_n = v[1:0];
        REG_TOTAL_0:    total[0] = v;
        REG_TOTAL_1:    total[1] = v;
        REG_TOTAL_2:    total[2] = v;
        REG_WIDTH_0:    width[0] = v[WID_W-1:0];
        REG_WIDTH_1:    width[1] = v[WID_W-1:0];
        REG_WIDTH_2:    width[2] = v[WID_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [31:0] flat, logic [15:0] coef, logic restart);
      logic [63:0]  rest;
      logic [63:0]  w;
      logic [63:0]  span;
      logic [63:0]  row;
      logic [63:0]  rem;
      int           c;
      int           n;
      loc_result_t  r;
      if (restart) usable_count = '0;
      n = active();
      rest = {32'd0, flat};
      c = 0;
      while (c < n && rest >= total[c]) begin
        rest = rest - total[c];
        c++;
      end
      r = '0;
      r.rank = usable_count;
      if (c >= n) begin
        r.oor = 1'b1;
      end else begin
        w = {50'd0, width[c]};
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = {50'd0, MAX_WIDTH};
        span = w * COEFS_PER_BLOCK;
        row = rest / span;
        rem = rest % span;
        r.comp = c[1:0];
        r.col = 13'(rem / COEFS_PER_BLOCK);
        r.pos = POS_W'(rem % COEFS_PER_BLOCK);
        r.row = (row > ROW_MAX) ? ROW_MAX : row[ROW_W-1:0];
        r.is_dc = (r.pos == 0);
        r.usable = !r.is_dc && (coef != 0);
        if (r.usable) usable_count = usable_count + 32'd1;
      end
      located_q.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
      fails++;
    endtask

    task check_result(logic [71:0] d, logic [2:0] u);
      loc_result_t got;
      loc_result_t want;
      got.comp   = d[1:0];
      got.row    = d[14:2];
      got.col    = d[27:15];
      got.pos    = d[33:28];
      got.rank   = d[65:34];
      got.is_dc  = u[0];
      got.usable = u[1];
      got.oor    = u[2];
      if (located_q.size() == 0) begin
        report("unexpected result beat", d[33:0], 0);
      end else begin
        want = located_q.pop_front();
        if (got.comp !== want.comp)     report("component", got.comp, want.comp);
        if (got.row !== want.row)       report("block_row", got.row, want.row);
        if (got.col !== want.col)       report("block_col", got.col, want.col);
        if (got.pos !== want.pos)       report("coef_pos", got.pos, want.pos);
        if (got.is_dc !== want.is_dc)   report("is_dc", got.is_dc, want.is_dc);
        if (got.usable !== want.usable) report("usable", got.usable, want.usable);
        if (got.rank !== want.rank)     report("usable_rank", got.rank, want.rank);
        if (got.oor !== want.oor)       report("out_of_range", got.oor, want.oor);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  locator_scoreboard sb;
  bit  quiet = 1'b0;
  bit  pressure_done = 1'b0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  ready_stall = 0;

  dct_coefficient_index_locator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Most gaps are short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Mostly indexes that land inside a component, then boundaries, indexes
  // past the end and raw noise.
  function automatic logic [31:0] gen_flat();
    int          n;
    int          mode;
    int          c;
    int          k;
    logic [63:0] base;
    logic [63:0] span;
    logic [63:0] v;
    n = sb.active();
    mode = $urandom_range(0, 99);
    base = '0;
    if (mode < 70) begin
      c = $urandom_range(0, n - 1);
      for (k = 0; k < c; k++) base = base + sb.total[k];
      span = sb.total[c];
      if (span == 0)
        v = base + $urandom_range(0, 3);
      else if ($urandom_range(0, 1) == 1)
        v = base + ({$urandom, $urandom} % span);
      else
        v = base + ($urandom_range(0, 8191) % span);
    end else if (mode < 82) begin
      c = $urandom_range(1, n);
      for (k = 0; k < c; k++) base = base + sb.total[k];
      v = base + $urandom_range(0, 2) - 1;
    end else if (mode < 90) begin
      for (k = 0; k < n; k++) base = base + sb.total[k];
      v = base + $urandom_range(0, 1000);
    end else begin
      v = $urandom;
    end
    return v[31:0];
  endfunction

  task cfg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task configure(int c_n, logic [31:0] t0, logic [31:0] t1, logic [31:0] t2,
                 logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
    cfg_write(REG_COMP_COUNT, 32'(c_n));
    cfg_write(REG_TOTAL_0, t0);
    cfg_write(REG_TOTAL_1, t1);
    cfg_write(REG_TOTAL_2, t2);
    cfg_write(REG_WIDTH_0, w0);
    cfg_write(REG_WIDTH_1, w1);
    cfg_write(REG_WIDTH_2, w2);
  endtask

  // Leaves tvalid high on return so that the next beat can follow at once.
  task send_item(logic [31:0] flat, logic [15:0] coef, logic restart);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {coef, flat};
    in_tuser  <= restart;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(flat, coef, restart);
    items_sent++;
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.located_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task send_random();
    logic [15:0] coef;
    coef = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
    send_item(gen_flat(), coef, $urandom_range(0, 31) == 0);
  endtask

  // Receiver: random stalls, plus one long hold-off once traffic is flowing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_stall > 0) begin
      out_tready <= 1'b0;
      ready_stall = ready_stall - 1;
    end else if (!pressure_done && items_sent >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      out_tready <= 1'b0;
      ready_stall = PRESSURE_LEN - 1;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      ready_stall = pick_gap();
      out_tready <= (ready_stall == 0);
      if (ready_stall > 0) ready_stall = ready_stall - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("dct_coefficient_index_locator_core verification failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every total is zero, so every index is out of range.
    send_item(32'd0, 16'd5, 1'b0);
    send_item(32'hffff_ffff, 16'h7fff, 1'b0);
    drain();

    configure(3, 32'd1000, 32'd5000, 32'hffff_ffff, 1, 7, 1);
    cfg_write(REG_UNUSED, $urandom);
    send_item(32'd0, 16'd100, 1'b1);
    send_item(32'd1, 16'd0, 1'b0);
    send_item(32'd1, 16'h8000, 1'b0);
    send_item(32'd63, 16'h7fff, 1'b0);
    send_item(32'd64, 16'hffff, 1'b0);
    send_item(32'd65, 16'd1, 1'b0);
    send_item(32'd999, 16'd3, 1'b0);
    send_item(32'd1000, 16'd3, 1'b0);
    send_item(32'd1001, 16'd3, 1'b0);
    send_item(32'd1447, 16'd5, 1'b0);
    send_item(32'd1448, 16'd5, 1'b0);
    send_item(32'd5999, 16'd2, 1'b0);
    send_item(32'd6000, 16'd2, 1'b0);
    // The last row that fits and the first rows that saturate.
    send_item(32'd6000 + 32'd8191 * 32'd64 + 32'd1, 16'd4, 1'b0);
    send_item(32'd6000 + 32'd8192 * 32'd64 + 32'd5, 16'd4, 1'b0);
    send_item(32'hffff_ffff, 16'd9, 1'b0);
    send_item(32'd5, 16'd7, 1'b1);
    send_item(32'd6, 16'd7, 1'b0);
    drain();

    // One component only: past its end the index is out of range, and a
    // restart still clears the count there.
    cfg_write(REG_COMP_COUNT, 32'd1);
    send_item(32'd999, 16'd1, 1'b0);
    send_item(32'd1000, 16'd1, 1'b1);
    send_item(32'd1001, 16'd1, 1'b0);
    send_item(32'd2, 16'd1, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(3, $urandom_range(1, 100000), $urandom_range(1, 100000),
                     $urandom_range(1, 100000), $urandom_range(1, 40),
                     $urandom_range(1, 40), $urandom_range(1, 40));
        1: configure(1, 32'hffff_ffff, $urandom, $urandom, 8192,
                     $urandom_range(1, 8192), $urandom_range(1, 8192));
        2: configure(2, $urandom, $urandom, $urandom, $urandom_range(0, 16383),
                     $urandom_range(0, 16383), $urandom_range(0, 16383));
        3: configure(0, $urandom_range(1, 1 << 20), $urandom, $urandom, 0,
                     $urandom_range(0, 16383), $urandom_range(0, 16383));
        4: configure(3, $urandom_range(1, 50000), 0, $urandom_range(1, 50000),
                     $urandom_range(1, 200), $urandom_range(1, 200),
                     $urandom_range(1, 200));
        5: configure(3, $urandom, $urandom, $urandom, 8192, 1,
                     $urandom_range(8192, 16383));
        6: configure(2, $urandom_range(1, 300), $urandom_range(1, 300),
                     $urandom_range(1, 300), $urandom_range(1, 3),
                     $urandom_range(1, 3), $urandom_range(1, 3));
        default: configure($urandom_range(0, 3), $urandom, $urandom, $urandom,
                           $urandom_range(0, 16383), $urandom_range(0, 16383),
                           $urandom_range(0, 16383));
      endcase
      if (ph == 2 || ph == 7) cfg_write(REG_UNUSED, $urandom);
      quiet = (ph == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      drain();
      quiet = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (sb.located_q.size() != 0) sb.report("results never delivered", sb.located_q.size(), 0);
    if (sb.fails == 0) begin
      $display("dct_coefficient_index_locator_core verification clean");
    end else begin
      $display("dct_coefficient_index_locator_core verification failed");
    end
    $finish;
  end

endmodule
